// ===== design/dlt_pkg.sv =====
// Shared definitions for the data language tokenizer.
// Holds the scanner mode encoding, token kind codes, the push control group
// and default widths. Depends on nothing.
`default_nettype none

package dlt_pkg;

   localparam int DEF_OFFSET_BITS = 32;
   localparam int DEF_LINE_BITS   = 24;

   localparam int KIND_BITS  = 3;
   localparam int PUNCT_BITS = 7;

   localparam logic [KIND_BITS-1:0] KIND_END    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_PUNCT  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_ERROR  = 3'd4;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_INT     = 4'd1,
      MODE_FRAC    = 4'd2,
      MODE_IDENT   = 4'd3,
      MODE_QUOTED  = 4'd4,
      MODE_SLASH   = 4'd5,
      MODE_LINECOM = 4'd6,
      MODE_BLOCK   = 4'd7,
      MODE_STAR    = 4'd8
   } mode_type;

   // Tokens written into the result queue in the same cycle.
   typedef struct packed {
      logic first;
      logic second;
   } push_ctrl_type;

endpackage

`default_nettype wire

// ===== design/dlt_token_fifo.sv =====
// Four-entry result queue for the tokenizer: takes up to two tokens per
// cycle from the scanner and hands one per cycle to the result port while it is ready.
// Depends on dlt_pkg for the push control group.
`default_nettype none

module dlt_token_fifo
   import dlt_pkg::*;
#(
   parameter int WIDTH = 96
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire push_ctrl_type    push,
   input  wire logic [WIDTH-1:0] din_first,
   input  wire logic [WIDTH-1:0] din_second,
   output logic                  space_ok,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      dout
);

   localparam int DEPTH      = 4;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, wr_in, wr_next;
   logic [PTR_BITS-1:0]   rd_ff, rd_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign dout      = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // Room for the worst case of two tokens from one byte.
   assign space_ok  = (count_ff <= COUNT_BITS'(DEPTH - 2));
   assign wr_next   = wr_ff + PTR_BITS'(1);

   always_comb begin
      wr_in    = wr_ff + PTR_BITS'(push.first) + PTR_BITS'(push.second);
      rd_in    = pop ? rd_ff + PTR_BITS'(1) : rd_ff;
      count_in = count_ff + COUNT_BITS'(push.first) + COUNT_BITS'(push.second)
                 - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ff] <= din_first;
      end
      if (push.second) begin
         mem_ff[wr_next] <= din_second;
      end
   end

endmodule

`default_nettype wire

// ===== design/dlt_scanner.sv =====
// Byte scanner of the tokenizer: input register, lexer state and the
// per-byte decision logic that yields up to two tokens per byte.
// Depends on dlt_pkg for modes, kind codes and the push control group.
`default_nettype none

module dlt_scanner
   import dlt_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int LINE_BITS   = DEF_LINE_BITS,
   parameter int TOKEN_BITS  = KIND_BITS + PUNCT_BITS + 2 + 2 * OFFSET_BITS + LINE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  in_eos,
   input  wire logic                  space_ok,
   output push_ctrl_type              push,
   output logic [TOKEN_BITS-1:0]      push_first_token,
   output logic [TOKEN_BITS-1:0]      push_second_token
);

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;

   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

   logic                   in_valid_ff;
   logic [7:0]             byte_ff;
   logic                   eos_ff;
   logic                   consume;

   mode_type               mode_ff, mode_in;
   logic                   quote_ff, quote_in;
   logic [OFFSET_BITS-1:0] pstart_ff, pstart_in;
   logic [LINE_BITS-1:0]   pline_ff, pline_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LINE_BITS-1:0]   cline_ff, cline_in;

   logic                   is_digit, is_alpha, is_ident;
   logic                   redo;

   logic                   a_valid, b_valid;
   logic [KIND_BITS-1:0]   a_kind, b_kind;
   logic [PUNCT_BITS-1:0]  a_punct, b_punct;
   logic                   a_quoted;
   logic [OFFSET_BITS-1:0] a_start, b_start, a_len, b_len;
   logic [LINE_BITS-1:0]   a_line;
   logic                   pend_valid;
   logic [TOKEN_BITS-1:0]  tok_a, tok_b;

   assign consume  = in_valid_ff && space_ok;
   assign in_ready = !in_valid_ff || space_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         eos_ff  <= in_eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         quote_ff  <= 1'b0;
         pstart_ff <= '0;
         pline_ff  <= LINE_ONE;
         offset_ff <= '0;
         cline_ff  <= LINE_ONE;
      end else if (consume) begin
         mode_ff   <= mode_in;
         quote_ff  <= quote_in;
         pstart_ff <= pstart_in;
         pline_ff  <= pline_in;
         offset_ff <= offset_in;
         cline_ff  <= cline_in;
      end
   end

   assign is_digit = (byte_ff >= CH_0) && (byte_ff <= CH_9);
   assign is_alpha = ((byte_ff >= CH_UA) && (byte_ff <= CH_UZ)) ||
                     ((byte_ff >= CH_LA) && (byte_ff <= CH_LZ));
   assign is_ident = is_alpha || is_digit || (byte_ff == CH_UNDER);

   always_comb begin
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      pstart_in = pstart_ff;
      pline_in  = pline_ff;
      offset_in = offset_ff + OFFSET_BITS'(1);
      cline_in  = ((byte_ff == CH_NL) && (cline_ff != '1)) ? cline_ff + LINE_ONE : cline_ff;
      redo      = 1'b0;

      // Token A: the pending token flushed by this byte, or a closed literal.
      a_valid    = 1'b0;
      pend_valid = 1'b0;
      a_kind     = KIND_END;
      a_punct    = '0;
      a_quoted   = 1'b0;
      a_start    = pstart_ff;
      a_len      = offset_ff - pstart_ff;
      a_line     = pline_ff;
      unique case (mode_ff)
         MODE_INT, MODE_FRAC: begin
            pend_valid = 1'b1;
            a_kind     = KIND_NUMBER;
         end
         MODE_IDENT: begin
            pend_valid = 1'b1;
            a_kind     = KIND_IDENT;
         end
         MODE_QUOTED: begin
            pend_valid = 1'b1;
            a_kind     = KIND_ERROR;
            a_quoted   = 1'b1;
         end
         MODE_SLASH: begin
            pend_valid = 1'b1;
            a_kind     = KIND_PUNCT;
            a_punct    = CH_SLASH[PUNCT_BITS-1:0];
            a_len      = OFFSET_BITS'(1);
         end
         default: begin
            pend_valid = 1'b0;
         end
      endcase

      // Token B: what the byte itself produces from idle, or the end marker.
      b_valid = 1'b0;
      b_kind  = KIND_END;
      b_punct = '0;
      b_start = offset_ff;
      b_len   = OFFSET_BITS'(1);

      if (eos_ff) begin
         a_valid   = pend_valid;
         b_valid   = 1'b1;
         b_len     = '0;
         mode_in   = MODE_IDLE;
         quote_in  = 1'b0;
         pstart_in = '0;
         pline_in  = LINE_ONE;
         offset_in = '0;
         cline_in  = LINE_ONE;
      end else begin
         unique case (mode_ff)
            MODE_INT: begin
               if (byte_ff == CH_DOT) begin
                  mode_in = MODE_FRAC;
               end else if (!is_digit) begin
                  a_valid = 1'b1;
                  redo    = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (!is_digit) begin
                  a_valid = 1'b1;
                  redo    = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (!is_ident) begin
                  a_valid = 1'b1;
                  redo    = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (byte_ff == (quote_ff ? CH_SQUOTE : CH_DQUOTE)) begin
                  a_valid = 1'b1;
                  a_kind  = KIND_IDENT;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_SLASH: begin
               if (byte_ff == CH_SLASH) begin
                  mode_in = MODE_LINECOM;
               end else if (byte_ff == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  a_valid = 1'b1;
                  redo    = 1'b1;
               end
            end
            MODE_LINECOM: begin
               if (byte_ff == CH_NL) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_BLOCK: begin
               if (byte_ff == CH_STAR) begin
                  mode_in = MODE_STAR;
               end
            end
            MODE_STAR: begin
               if (byte_ff == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (byte_ff != CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: begin
               redo = 1'b1;
            end
         endcase

         if (redo) begin
            mode_in = MODE_IDLE;
            if (is_digit) begin
               mode_in   = MODE_INT;
               pstart_in = offset_ff;
               pline_in  = cline_ff;
            end else if (is_alpha || (byte_ff == CH_UNDER)) begin
               mode_in   = MODE_IDENT;
               pstart_in = offset_ff;
               pline_in  = cline_ff;
            end else if ((byte_ff == CH_DQUOTE) || (byte_ff == CH_SQUOTE)) begin
               // Skip the opening quote.
               mode_in   = MODE_QUOTED;
               pstart_in = offset_ff + OFFSET_BITS'(1);
               pline_in  = cline_ff;
               quote_in  = (byte_ff == CH_SQUOTE);
            end else if (byte_ff == CH_SLASH) begin
               mode_in   = MODE_SLASH;
               pstart_in = offset_ff;
               pline_in  = cline_ff;
            end else if ((byte_ff == CH_SPACE) || (byte_ff == CH_TAB) ||
                         (byte_ff == CH_CR) || (byte_ff == CH_NL)) begin
               mode_in = MODE_IDLE;
            end else if ((byte_ff == 8'h00) || byte_ff[7]) begin
               b_valid = 1'b1;
            end else begin
               b_valid = 1'b1;
               b_kind  = KIND_PUNCT;
               b_punct = byte_ff[PUNCT_BITS-1:0];
            end
         end
      end
   end

   // Fields from the lowest bit: kind, punct, quoted, start, length, line, last.
   assign tok_a = {!b_valid, a_line, a_len, a_start, a_quoted, a_punct, a_kind};
   assign tok_b = {1'b1, cline_ff, b_len, b_start, 1'b0, b_punct, b_kind};

   assign push.first        = consume && (a_valid || b_valid);
   assign push.second       = consume && a_valid && b_valid;
   assign push_first_token  = a_valid ? tok_a : tok_b;
   assign push_second_token = tok_b;

endmodule

`default_nettype wire

// ===== design/data_language_tokenizer.sv =====
// Streaming lexer for a small data language: one text byte per input word,
// numbers, identifiers, quoted literals and punctuation out as token words
// with start offset, length and starting line. A byte is registered, scanned
// from that register and its tokens land in a four-entry queue that drives
// the result port, so the block sustains one byte per cycle while the queue
// has room. A byte is scanned only while the queue has two free slots; since
// the result port moves at most one token per cycle, a byte that yields two
// tokens (pending token flushed plus the byte's own token, or the end word)
// holds back the input under steady load. The end word (tuser set) flushes the
// pending token, emits an end token and returns the lexer to its reset state.
// Depends on dlt_pkg, dlt_scanner and dlt_token_fifo.
`default_nettype none

module data_language_tokenizer
   import dlt_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int LINE_BITS   = DEF_LINE_BITS,
   localparam int RSP_FIELD_BITS = PUNCT_BITS + 2 * OFFSET_BITS + LINE_BITS,
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,  // data_byte
   input  wire logic [0:0]               req_tuser,  // end_of_stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // punct_char, token_start, token_length, token_line, zero fill
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic [3:0]                    rsp_tuser,  // token_kind[2:0], is_quoted
   output logic                          rsp_tlast   // last_of_run
);

   localparam int PUNCT_LSB  = KIND_BITS;
   localparam int QUOTED_BIT = PUNCT_LSB + PUNCT_BITS;
   localparam int START_LSB  = QUOTED_BIT + 1;
   localparam int LAST_BIT   = START_LSB + 2 * OFFSET_BITS + LINE_BITS;
   localparam int TOKEN_BITS = LAST_BIT + 1;

   push_ctrl_type         push;
   logic [TOKEN_BITS-1:0] first_token, second_token, head_token;
   logic                  space_ok;

   dlt_scanner #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .TOKEN_BITS  (TOKEN_BITS)
   ) u_scanner (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_tvalid),
      .in_ready          (req_tready),
      .in_byte           (req_tdata),
      .in_eos            (req_tuser[0]),
      .space_ok          (space_ok),
      .push              (push),
      .push_first_token  (first_token),
      .push_second_token (second_token)
   );

   dlt_token_fifo #(
      .WIDTH (TOKEN_BITS)
   ) u_token_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .din_first  (first_token),
      .din_second (second_token),
      .space_ok   (space_ok),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .dout       (head_token)
   );

   // Drop the quoted flag out of the data word; it travels in tuser.
   assign rsp_tdata = RSP_DATA_BITS'({head_token[LAST_BIT-1:START_LSB],
                                      head_token[QUOTED_BIT-1:PUNCT_LSB]});
   assign rsp_tuser = {head_token[QUOTED_BIT], head_token[KIND_BITS-1:0]};
   assign rsp_tlast = head_token[LAST_BIT];

   // Punctuation character is zero on every non-punctuation token.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[KIND_BITS-1:0] != KIND_PUNCT)) |->
         (rsp_tdata[PUNCT_BITS-1:0] == '0))
      else $error("punct_char set on non-punctuation token");

   // A zero-length end token closes the run of its word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[KIND_BITS-1:0] == KIND_END) &&
       (rsp_tdata[PUNCT_BITS+2*OFFSET_BITS-1:PUNCT_BITS+OFFSET_BITS] == '0)) |->
         rsp_tlast)
      else $error("stream end token not marked last");

   // The line counter starts at one and never wraps to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_FIELD_BITS-1:PUNCT_BITS+2*OFFSET_BITS] != '0))
      else $error("token line is zero");

   // The queue is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== tb/sv/data_language_tokenizer_tb.sv =====
// Self-checking bench for the data language tokenizer: random and directed text bytes in,
// token words checked against a scoreboard that tracks the lexer state itself.
// Depends on dlt_pkg and data_language_tokenizer.
`default_nettype none

module data_language_tokenizer_tb;
   import dlt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFF_W  = DEF_OFFSET_BITS;
   localparam int LINE_W = DEF_LINE_BITS;
   localparam int RSP_W  = ((PUNCT_BITS + 2 * OFF_W + LINE_W + 7) / 8) * 8;

   localparam int PHASE_WORDS = 440;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   typedef struct {
      logic [KIND_BITS-1:0]  kind;
      logic [PUNCT_BITS-1:0] punct;
      logic                  quoted;
      logic [OFF_W-1:0]      start;
      logic [OFF_W-1:0]      length;
      logic [LINE_W-1:0]     line;
      logic                  last;
   } token_type;

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   class token_scoreboard;
      token_type        expected_tokens[$];
      token_type        step_tokens[$];
      mode_type         mode;
      bit               single_quote;
      logic [OFF_W-1:0]  pend_start;
      logic [LINE_W-1:0] pend_line;
      logic [OFF_W-1:0]  offset;
      logic [LINE_W-1:0] line;
      int mismatches;
      int tokens_checked;

      function new();
         clear_state();
         mismatches = 0;
         tokens_checked = 0;
      endfunction

      function void clear_state();
         mode = MODE_IDLE;
         single_quote = 0;
         pend_start = '0;
         pend_line = 1;
         offset = '0;
         line = 1;
      endfunction

      function void add(logic [KIND_BITS-1:0] kind, logic [PUNCT_BITS-1:0] punct,
                        logic quoted, logic [OFF_W-1:0] start, logic [OFF_W-1:0] length,
                        logic [LINE_W-1:0] ln);
         token_type t;
         t.kind = kind;
         t.punct = punct;
         t.quoted = quoted;
         t.start = start;
         t.length = length;
         t.line = ln;
         t.last = 0;
         step_tokens.push_back(t);
      endfunction

      function void begin_pending(mode_type m, logic [OFF_W-1:0] start);
         mode = m;
         pend_start = start;
         pend_line = line;
      endfunction

      function void flush_pending(logic [OFF_W-1:0] off);
         case (mode)
            MODE_INT, MODE_FRAC: add(KIND_NUMBER, 0, 0, pend_start, off - pend_start, pend_line);
            MODE_IDENT:  add(KIND_IDENT, 0, 0, pend_start, off - pend_start, pend_line);
            MODE_QUOTED: add(KIND_ERROR, 0, 1, pend_start, off - pend_start, pend_line);
            MODE_SLASH:  add(KIND_PUNCT, CH_SLASH[6:0], 0, pend_start, 1, pend_line);
            default: ;
         endcase
      endfunction

      function void note_word(logic [7:0] b, logic eos);
         logic [OFF_W-1:0] off;
         bit rescan;
         off = offset;
         rescan = 0;
         step_tokens.delete();
         if (eos) begin
            flush_pending(off);
            add(KIND_END, 0, 0, off, 0, line);
            clear_state();
         end else begin
            case (mode)
               MODE_INT: begin
                  if (b == CH_DOT) mode = MODE_FRAC;
                  else if (!is_digit(b)) begin
                     flush_pending(off);
                     rescan = 1;
                  end
               end
               MODE_FRAC: begin
                  if (!is_digit(b)) begin
                     flush_pending(off);
                     rescan = 1;
                  end
               end
               MODE_IDENT: begin
                  if (!(is_alpha(b) || is_digit(b) || b == CH_UNDER)) begin
                     flush_pending(off);
                     rescan = 1;
                  end
               end
               MODE_QUOTED: begin
                  if (b == (single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                     add(KIND_IDENT, 0, 1, pend_start, off - pend_start, pend_line);
                     mode = MODE_IDLE;
                  end
               end
               MODE_SLASH: begin
                  if (b == CH_SLASH) mode = MODE_LINECOM;
                  else if (b == CH_STAR) mode = MODE_BLOCK;
                  else begin
                     flush_pending(off);
                     rescan = 1;
                  end
               end
               MODE_LINECOM: if (b == CH_LF) mode = MODE_IDLE;
               MODE_BLOCK:   if (b == CH_STAR) mode = MODE_STAR;
               MODE_STAR: begin
                  if (b == CH_SLASH) mode = MODE_IDLE;
                  else if (b != CH_STAR) mode = MODE_BLOCK;
               end
               default: rescan = 1;
            endcase
            // treat the byte as the first one of a new token
            if (rescan) begin
               mode = MODE_IDLE;
               if (is_digit(b)) begin_pending(MODE_INT, off);
               else if (is_alpha(b) || b == CH_UNDER) begin_pending(MODE_IDENT, off);
               else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                  begin_pending(MODE_QUOTED, off + 1);
                  single_quote = (b == CH_SQUOTE);
               end else if (b == CH_SLASH) begin_pending(MODE_SLASH, off);
               else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) ;
               else if (b == 8'h00 || b[7]) add(KIND_END, 0, 0, off, 1, line);
               else add(KIND_PUNCT, b[6:0], 0, off, 1, line);
            end
            if (b == CH_LF && line != '1) line++;
            offset = off + 1;
         end
         if (step_tokens.size() > 0) step_tokens[$].last = 1;
         foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_token(token_type got);
         token_type exp;
         tokens_checked++;
         if (expected_tokens.size() == 0) begin
            report($sformatf("unexpected token kind=%0d start=%0d len=%0d",
                             got.kind, got.start, got.length));
            return;
         end
         exp = expected_tokens.pop_front();
         if (exp.kind !== got.kind || exp.punct !== got.punct || exp.quoted !== got.quoted ||
             exp.start !== got.start || exp.length !== got.length ||
             exp.line !== got.line || exp.last !== got.last)
            report($sformatf({"token mismatch exp kind=%0d ch=%h q=%0d start=%0d len=%0d ",
                              "line=%0d last=%0d got kind=%0d ch=%h q=%0d start=%0d len=%0d ",
                              "line=%0d last=%0d"},
                             exp.kind, exp.punct, exp.quoted, exp.start, exp.length,
                             exp.line, exp.last, got.kind, got.punct, got.quoted,
                             got.start, got.length, got.line, got.last));
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;
   logic [0:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [3:0]       rsp_tuser;
   logic             rsp_tlast;

   token_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 0;
   int words_sent = 0;
   int end_words = 0;
   int cycle_count = 0;

   data_language_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_word(req_tdata, req_tuser[0]);
   end

   always @(posedge clock) begin
      token_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.punct  = rsp_tdata[PUNCT_BITS-1:0];
         got.start  = rsp_tdata[PUNCT_BITS +: OFF_W];
         got.length = rsp_tdata[PUNCT_BITS + OFF_W +: OFF_W];
         got.line   = rsp_tdata[PUNCT_BITS + 2 * OFF_W +: LINE_W];
         got.kind   = rsp_tuser[KIND_BITS-1:0];
         got.quoted = rsp_tuser[KIND_BITS];
         got.last   = rsp_tlast;
         sb.check_token(got);
      end
   end

   // receiver: random stalls, plus one long hold-off to back the block up
   initial begin
      int held;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_request && held < HOLD_CYCLES) begin
            rsp_tready <= 0;
            held++;
         end else
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_word(logic [7:0] b, logic eos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= b;
      req_tuser  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (eos) end_words++;
   endtask

   task automatic put_byte(logic [7:0] b);
      send_word(b, 0);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic end_stream();
      send_word(8'($urandom_range(0, 255)), 1);
   endtask

   function automatic logic [7:0] rand_punct();
      logic [7:0] c;
      c = 8'($urandom_range(33, 126));
      while (is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_SQUOTE ||
             c == CH_DQUOTE || c == CH_SLASH)
         c = 8'($urandom_range(33, 126));
      return c;
   endfunction

   function automatic logic [7:0] rand_ident_char(bit head);
      int sel;
      sel = $urandom_range(0, head ? 52 : 62);
      if (sel < 26) return 8'("a" + sel);
      if (sel < 52) return 8'("A" + sel - 26);
      if (sel == 52) return CH_UNDER;
      return 8'("0" + sel - 53);
   endfunction

   // mostly printable, sometimes any byte value
   function automatic logic [7:0] rand_body_char();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic send_piece();
      int sel;
      int n;
      logic [7:0] q;
      logic [7:0] c;
      sel = $urandom_range(0, 99);
      if (sel < 18) begin
         n = $urandom_range(1, 6);
         repeat (n) put_byte(8'("0" + $urandom_range(0, 9)));
         if ($urandom_range(0, 1)) begin
            put_byte(CH_DOT);
            n = $urandom_range(0, 4);
            repeat (n) put_byte(8'("0" + $urandom_range(0, 9)));
         end
      end else if (sel < 36) begin
         put_byte(rand_ident_char(1));
         n = $urandom_range(0, 7);
         repeat (n) put_byte(rand_ident_char(0));
      end else if (sel < 46) begin
         q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
         put_byte(q);
         n = $urandom_range(0, 6);
         repeat (n) begin
            c = rand_body_char();
            put_byte(c == q ? "x" : c);
         end
         put_byte(q);
      end else if (sel < 52) begin
         put_byte(CH_SLASH);
         put_byte(CH_SLASH);
         n = $urandom_range(0, 8);
         repeat (n) begin
            c = rand_body_char();
            put_byte(c == CH_LF ? "c" : c);
         end
         put_byte(CH_LF);
      end else if (sel < 58) begin
         put_byte(CH_SLASH);
         put_byte(CH_STAR);
         n = $urandom_range(0, 8);
         repeat (n) put_byte($urandom_range(0, 2) == 0 ? CH_STAR : rand_body_char());
         put_byte(CH_STAR);
         put_byte(CH_SLASH);
      end else if (sel < 70) begin
         case ($urandom_range(0, 3))
            0: put_byte(CH_SPACE);
            1: put_byte(CH_TAB);
            2: put_byte(CH_CR);
            default: put_byte(CH_LF);
         endcase
      end else if (sel < 80) begin
         put_byte(rand_punct());
      end else if (sel < 84) begin
         put_byte(CH_SLASH);
      end else if (sel < 86) begin
         put_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255)));
      end else if (sel < 89) begin
         end_stream();
      end else if (sel < 93) begin
         // cut a literal or comment short with an end word
         case ($urandom_range(0, 2))
            0: put_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
            1: begin
               put_byte(CH_SLASH);
               put_byte(CH_STAR);
            end
            default: begin
               put_byte(CH_SLASH);
               put_byte(CH_SLASH);
            end
         endcase
         n = $urandom_range(0, 3);
         repeat (n) put_byte(8'("a" + $urandom_range(0, 25)));
         end_stream();
      end else begin
         n = $urandom_range(1, 3);
         repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: number forms, quotes, both comments, lone slash, end bytes, flushes
      put_text("1..");
      put_text("_a9'x\"'\"\"//");
      put_byte(8'h80);
      put_text("\n/**/ /;");
      put_byte(8'h00);
      put_byte(8'hFF);
      put_text("a");
      end_stream();
      put_text("'u");
      end_stream();
      put_text("/*");
      end_stream();
      put_text("/");
      end_stream();
      end_stream();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               hold_request = 1;
            end
            1: begin
               send_idle_pct = 68;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 68;
            end
            default: begin
               send_idle_pct = 23;
               recv_stall_pct = 23;
            end
         endcase
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) send_piece();
         end_stream();
      end
      req_tvalid <= 0;

      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d text words (%0d end words) through four handshake phases",
               words_sent, end_words);
      $display("Checked %0d tokens, %0d still expected, %0d mismatches",
               sb.tokens_checked, sb.expected_tokens.size(), sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/dlt_pkg.sv
design/dlt_token_fifo.sv
design/dlt_scanner.sv
design/data_language_tokenizer.sv
tb/sv/data_language_tokenizer_tb.sv
